// File: hdl/lfs_pkg.sv
// Shared types, codes and constants for the launcher fire sequencer.
// No dependencies; every other file imports this package.
`default_nettype none

package lfs_pkg;

  // Timer width and the width used for timer compares
  localparam int unsigned TimerBits = 20;
  localparam int unsigned TimeoutW  = 20;
  localparam int unsigned CmpW      = (TimerBits > TimeoutW) ? TimerBits : TimeoutW;

  // Configuration port
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] RegSpinup   = 2'd0;
  localparam logic [1:0] RegTimeout  = 2'd1;
  localparam logic [1:0] RegPower    = 2'd2;
  localparam logic [1:0] RegNeutral  = 2'd3;

  // Input modes
  localparam logic [2:0] ModeTick   = 3'd0;
  localparam logic [2:0] ModeArm    = 3'd1;
  localparam logic [2:0] ModeDisarm = 3'd2;
  localparam logic [2:0] ModeFire   = 3'd3;
  localparam logic [2:0] ModeSetPush = 3'd4;

  // Sequence phases
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhSpin = 2'd1;
  localparam logic [1:0] PhPush = 2'd2;

  // Result events
  typedef enum logic [2:0] {
    EvNone       = 3'd0,
    EvNotArmed   = 3'd1,
    EvStarted    = 3'd2,
    EvComplete   = 3'd3,
    EvAutoDisarm = 3'd4,
    EvBusy       = 3'd5
  } event_e;

  // Pulse widths, power clamp and reset values
  localparam logic [10:0] FlyStopUs   = 11'd1000;
  localparam logic [10:0] FlyMaxUs    = 11'd1800;
  localparam logic [11:0] PushDriveUs = 12'd2500;
  localparam logic [6:0]  PowerClamp  = 7'd80;
  localparam logic [15:0] SpinupRst   = 16'd1200;
  localparam logic [19:0] TimeoutRst  = 20'd60000;
  localparam logic [6:0]  PowerRst    = 7'd50;
  localparam logic [11:0] NeutralRst  = 12'd1500;
  localparam logic [15:0] PushTimeRst = 16'd500;

  // Configuration register set
  typedef struct packed {
    logic [15:0] spin_delay_ms;
    logic [19:0] idle_timeout_ms;
    logic [6:0]  flywheel_power_pct;
    logic [11:0] pusher_neutral_us;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic        armed;
    logic [1:0]  phase;
    logic [10:0] flywheel_us;
    logic        pusher_enabled;
    logic [11:0] pusher_us;
    event_e      event_res;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/lfs_cfg_regs.sv
// APB-style configuration registers of the launcher fire sequencer.
// Depends on lfs_pkg.
`default_nettype none

module lfs_cfg_regs
  import lfs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output      logic [DataW-1:0] prdata,
  output      logic             pready,
  output      cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  // Register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spin_delay_ms      <= SpinupRst;
      cfg_q.idle_timeout_ms    <= TimeoutRst;
      cfg_q.flywheel_power_pct <= PowerRst;
      cfg_q.pusher_neutral_us  <= NeutralRst;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegSpinup:  cfg_q.spin_delay_ms      <= pwdata[15:0];
        RegTimeout: cfg_q.idle_timeout_ms    <= pwdata[19:0];
        RegPower:   cfg_q.flywheel_power_pct <= pwdata[6:0];
        RegNeutral: cfg_q.pusher_neutral_us  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (paddr[3:2])
      RegSpinup:  prdata = {16'd0, cfg_q.spin_delay_ms};
      RegTimeout: prdata = {12'd0, cfg_q.idle_timeout_ms};
      RegPower:   prdata = {25'd0, cfg_q.flywheel_power_pct};
      RegNeutral: prdata = {20'd0, cfg_q.pusher_neutral_us};
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/lfs_core.sv
// Sequencer state and its combinational next-state update for one accepted beat.
// Depends on lfs_pkg; produces the result beat for the output buffer.
`default_nettype none

module lfs_core
  import lfs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [2:0]  mode_i,
  input  wire logic [15:0] duration_ms_i,
  input  wire cfg_t        cfg_i,
  output      res_t        res_o
);

  logic                 armed_q, armed_d;
  logic [1:0]           phase_q, phase_d;
  logic [TimerBits-1:0] ph_el_q, ph_el_d;
  logic [TimerBits-1:0] idle_el_q, idle_el_d;
  logic [15:0]          push_time_q, push_time_d;
  logic [10:0]          fly_q, fly_d;
  logic                 pusher_q, pusher_d;

  logic [TimerBits-1:0] idle_inc, ph_inc;
  logic [6:0]           pct_clamped;
  logic [10:0]          fly_raw, fire_us;
  event_e               ev;

  // Saturating timer increments
  assign idle_inc = (idle_el_q == '1) ? idle_el_q : idle_el_q + 1'b1;
  assign ph_inc   = (ph_el_q == '1) ? ph_el_q : ph_el_q + 1'b1;

  // Power percent to flywheel pulse
  assign pct_clamped = (cfg_i.flywheel_power_pct > PowerClamp) ? PowerClamp
                                                               : cfg_i.flywheel_power_pct;
  assign fly_raw = FlyStopUs + 11'(pct_clamped) * 11'd10;
  assign fire_us = (fly_raw > FlyMaxUs) ? FlyMaxUs : fly_raw;

  // Next state
  always_comb begin
    armed_d     = armed_q;
    phase_d     = phase_q;
    ph_el_d     = ph_el_q;
    idle_el_d   = idle_el_q;
    push_time_d = push_time_q;
    fly_d       = fly_q;
    pusher_d    = pusher_q;
    ev          = EvNone;
    case (mode_i)
      ModeTick: begin
        idle_el_d = idle_inc;
        if (armed_q && phase_q == PhIdle &&
            CmpW'(idle_inc) > CmpW'(cfg_i.idle_timeout_ms)) begin
          armed_d  = 1'b0;
          phase_d  = PhIdle;
          fly_d    = FlyStopUs;
          pusher_d = 1'b0;
          ev       = EvAutoDisarm;
        end else if (phase_q == PhSpin) begin
          ph_el_d = ph_inc;
          if (CmpW'(ph_inc) >= CmpW'(cfg_i.spin_delay_ms)) begin
            phase_d  = PhPush;
            pusher_d = 1'b1;
            ph_el_d  = '0;
          end
        end else if (phase_q == PhPush) begin
          ph_el_d = ph_inc;
          if (CmpW'(ph_inc) >= CmpW'(push_time_q)) begin
            phase_d  = PhIdle;
            pusher_d = 1'b0;
            fly_d    = FlyStopUs;
            ev       = EvComplete;
          end
        end
      end
      ModeArm: begin
        armed_d   = 1'b1;
        fly_d     = FlyStopUs;
        idle_el_d = '0;
      end
      ModeDisarm: begin
        armed_d  = 1'b0;
        phase_d  = PhIdle;
        fly_d    = FlyStopUs;
        pusher_d = 1'b0;
      end
      ModeFire: begin
        if (!armed_q) begin
          ev = EvNotArmed;
        end else if (phase_q != PhIdle) begin
          ev = EvBusy;
        end else begin
          if (duration_ms_i != '0) push_time_d = duration_ms_i;
          fly_d     = fire_us;
          phase_d   = PhSpin;
          ph_el_d   = '0;
          idle_el_d = '0;
          ev        = EvStarted;
        end
      end
      ModeSetPush: begin
        push_time_d = duration_ms_i;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      phase_q     <= PhIdle;
      ph_el_q     <= '0;
      idle_el_q   <= '0;
      push_time_q <= PushTimeRst;
      fly_q       <= FlyStopUs;
      pusher_q    <= 1'b0;
    end else if (accept_i) begin
      armed_q     <= armed_d;
      phase_q     <= phase_d;
      ph_el_q     <= ph_el_d;
      idle_el_q   <= idle_el_d;
      push_time_q <= push_time_d;
      fly_q       <= fly_d;
      pusher_q    <= pusher_d;
    end
  end

  // Result beat reflects state after the item
  always_comb begin
    res_o.armed          = armed_d;
    res_o.phase          = phase_d;
    res_o.flywheel_us    = fly_d;
    res_o.pusher_enabled = pusher_d;
    res_o.pusher_us      = pusher_d ? PushDriveUs : cfg_i.pusher_neutral_us;
    res_o.event_res      = ev;
  end

endmodule

`default_nettype wire

// File: hdl/lfs_out_buf.sv
// Two-entry output buffer (main register plus skid) for result beats.
// Depends on lfs_pkg.
`default_nettype none

module lfs_out_buf
  import lfs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_ready_o,
  input  wire res_t in_res_i,
  output      logic out_valid_o,
  input  wire logic out_ready_i,
  output      res_t out_res_o
);

  res_t main_q, skid_q;
  logic main_v_q, skid_v_q;
  logic push, pop;

  assign in_ready_o  = !skid_v_q;
  assign push        = in_valid_i & in_ready_o;
  assign pop         = main_v_q & out_ready_i;
  assign out_valid_o = main_v_q;
  assign out_res_o   = main_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) skid_v_q <= 1'b0;
    end else if (push) begin
      if (!main_v_q || pop) main_v_q <= 1'b1;
      else                  skid_v_q <= 1'b1;
    end else if (pop) begin
      main_v_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) main_q <= skid_q;
    end else if (push) begin
      if (!main_v_q || pop) main_q <= in_res_i;
      else                  skid_q <= in_res_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/launcher_fire_sequencer.sv
// Launcher fire sequencer: one state update per beat with one result each.
// Depends on lfs_pkg, lfs_cfg_regs, lfs_core and lfs_out_buf.
//
// Each input beat (a 1 ms tick or a command) is taken on a handshake and
// yields exactly one registered result beat. A new beat can be accepted
// every cycle while the skid entry is empty; the sequencer state is updated
// by one short combinational pass per beat, and a two-entry output buffer
// lets input keep flowing while a result waits, so throughput is one beat
// per cycle as long as the consumer keeps up. Configuration registers sit at
// byte offsets 0x0 spin-up, 0x4 idle timeout, 0x8 power percent and 0xC
// pusher neutral pulse; write them only while no beat is in flight.
`default_nettype none

module launcher_fire_sequencer
  import lfs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output      logic [DataW-1:0] prdata,
  output      logic             pready,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic [2:0]       mode_i,
  input  wire logic [15:0]      duration_ms_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic             armed_o,
  output      logic [1:0]       phase_o,
  output      logic [10:0]      flywheel_us_o,
  output      logic             pusher_enabled_o,
  output      logic [11:0]      pusher_us_o,
  output      logic [2:0]       event_res_o
);

  cfg_t cfg;
  res_t core_res, out_res;
  logic accept;

  assign accept = in_valid_i & in_ready_o;

  lfs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lfs_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .mode_i        (mode_i),
    .duration_ms_i (duration_ms_i),
    .cfg_i         (cfg),
    .res_o         (core_res)
  );

  lfs_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_res_i    (core_res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res)
  );

  // Result fields to ports
  assign armed_o          = out_res.armed;
  assign phase_o          = out_res.phase;
  assign flywheel_us_o    = out_res.flywheel_us;
  assign pusher_enabled_o = out_res.pusher_enabled;
  assign pusher_us_o      = out_res.pusher_us;
  assign event_res_o      = out_res.event_res;

endmodule

`default_nettype wire

// File: hdl/lfs_checker.sv
// Port-level checker for the launcher fire sequencer, bound to the top level.
// Depends on lfs_pkg for phase, pulse and event codes.
`default_nettype none

module lfs_checker
  import lfs_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        armed_o,
  input wire logic [1:0]  phase_o,
  input wire logic [10:0] flywheel_us_o,
  input wire logic        pusher_enabled_o,
  input wire logic [2:0]  event_res_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(phase_o) &&
    $stable(event_res_o) && $stable(flywheel_us_o))
    else $error("result beat changed while stalled");

  // A sequence in progress implies armed
  a_busy_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_o != PhIdle |-> armed_o)
    else $error("sequence running while disarmed");

  // Pusher only driven in the push phase
  a_pusher_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pusher_enabled_o |-> phase_o == PhPush)
    else $error("pusher driven outside push phase");

  // Idle means flywheels stopped and pusher released
  a_idle_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_o == PhIdle |-> flywheel_us_o == FlyStopUs && !pusher_enabled_o)
    else $error("flywheels or pusher active while idle");

  // A started fire enters spin-up armed
  a_start_spin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EvStarted |-> phase_o == PhSpin && armed_o)
    else $error("fire started without entering spin-up");

endmodule

bind launcher_fire_sequencer lfs_checker u_lfs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .armed_o          (armed_o),
  .phase_o          (phase_o),
  .flywheel_us_o    (flywheel_us_o),
  .pusher_enabled_o (pusher_enabled_o),
  .event_res_o      (event_res_o)
);

`default_nettype wire

// File: tb/launcher_fire_sequencer_test.sv
// Self-checking testbench for launcher_fire_sequencer: random and directed beats,
// APB register programming, and a beat-level model of the firing sequence.
// Depends on lfs_pkg and the launcher_fire_sequencer RTL only.
`default_nettype none

module launcher_fire_sequencer_test;
  import lfs_pkg::*;

  // Modes the block leaves alone
  localparam logic [2:0] ModeSpareLo = 3'd5;
  localparam logic [2:0] ModeSpareHi = 3'd7;

  localparam int unsigned HoldCycles = 80;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned PhaseBeats = 120;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] dur;
  } beat_t;

  // Model of the sequencer state
  typedef struct {
    logic        armed;
    logic [1:0]  ph;
    logic [19:0] ph_ms;
    logic [19:0] idle_ms;
    logic [15:0] push_ms;
    logic [10:0] fly_us;
    logic        pusher_on;
  } launcher_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [AddrW-1:0] paddr         = '0;
  logic [DataW-1:0] pwdata        = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i    = 1'b0;
  logic             in_ready_o;
  logic [2:0]       mode_i        = ModeTick;
  logic [15:0]      duration_ms_i = '0;
  logic             out_valid_o;
  logic             out_ready_i   = 1'b0;
  logic             armed_o;
  logic [1:0]       phase_o;
  logic [10:0]      flywheel_us_o;
  logic             pusher_enabled_o;
  logic [11:0]      pusher_us_o;
  logic [2:0]       event_res_o;

  launcher_t   lnch;
  cfg_t        cfg_shadow;
  res_t        awaited_results[$];
  beat_t       send_q[$];

  int unsigned issue_count    = 0;
  int unsigned accept_count   = 0;
  int unsigned results_seen   = 0;
  int unsigned queued_cmds    = 0;
  int unsigned reg_writes     = 0;
  int unsigned mismatch_count = 0;
  int unsigned shots_done     = 0;
  int unsigned auto_disarms   = 0;
  int unsigned busy_refusals  = 0;
  int unsigned hold_requests  = 0;

  launcher_fire_sequencer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .duration_ms_i    (duration_ms_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .armed_o          (armed_o),
    .phase_o          (phase_o),
    .flywheel_us_o    (flywheel_us_o),
    .pusher_enabled_o (pusher_enabled_o),
    .pusher_us_o      (pusher_us_o),
    .event_res_o      (event_res_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Sequencer model
  // ---------------------------------------------------------------------------

  // Timers saturate at all ones
  function automatic logic [19:0] bump_ms(input logic [19:0] t);
    return (t == '1) ? t : t + 20'd1;
  endfunction

  function automatic void go_safe();
    lnch.armed     = 1'b0;
    lnch.ph        = PhIdle;
    lnch.fly_us    = FlyStopUs;
    lnch.pusher_on = 1'b0;
  endfunction

  function automatic void reset_launcher();
    cfg_shadow.spin_delay_ms      = SpinupRst;
    cfg_shadow.idle_timeout_ms    = TimeoutRst;
    cfg_shadow.flywheel_power_pct = PowerRst;
    cfg_shadow.pusher_neutral_us  = NeutralRst;
    lnch.ph_ms   = '0;
    lnch.idle_ms = '0;
    lnch.push_ms = PushTimeRst;
    go_safe();
  endfunction

  // Advance the model by one beat and return the outputs it leaves behind
  function automatic res_t step_launcher(input logic [2:0] mode, input logic [15:0] dur);
    event_e      ev;
    res_t        r;
    int unsigned pct;
    int unsigned us;
    ev = EvNone;
    case (mode)
      ModeTick: begin
        lnch.idle_ms = bump_ms(lnch.idle_ms);
        if (lnch.armed && lnch.ph == PhIdle &&
            lnch.idle_ms > cfg_shadow.idle_timeout_ms) begin
          go_safe();
          ev = EvAutoDisarm;
        end else if (lnch.ph == PhSpin) begin
          lnch.ph_ms = bump_ms(lnch.ph_ms);
          if (lnch.ph_ms >= 20'(cfg_shadow.spin_delay_ms)) begin
            lnch.ph        = PhPush;
            lnch.pusher_on = 1'b1;
            lnch.ph_ms     = '0;
          end
        end else if (lnch.ph == PhPush) begin
          lnch.ph_ms = bump_ms(lnch.ph_ms);
          if (lnch.ph_ms >= 20'(lnch.push_ms)) begin
            lnch.ph        = PhIdle;
            lnch.pusher_on = 1'b0;
            lnch.fly_us    = FlyStopUs;
            ev             = EvComplete;
          end
        end
      end
      ModeArm: begin
        lnch.armed   = 1'b1;
        lnch.fly_us  = FlyStopUs;
        lnch.idle_ms = '0;
      end
      ModeDisarm: go_safe();
      ModeFire: begin
        if (!lnch.armed) begin
          ev = EvNotArmed;
        end else if (lnch.ph != PhIdle) begin
          ev = EvBusy;
        end else begin
          if (dur != '0) lnch.push_ms = dur;
          // power percent -> pulse width, clamped then capped
          pct = (cfg_shadow.flywheel_power_pct > PowerClamp) ?
                PowerClamp : cfg_shadow.flywheel_power_pct;
          us  = FlyStopUs + 10 * pct;
          if (us > FlyMaxUs) us = FlyMaxUs;
          lnch.fly_us  = 11'(us);
          lnch.ph      = PhSpin;
          lnch.ph_ms   = '0;
          lnch.idle_ms = '0;
          ev           = EvStarted;
        end
      end
      ModeSetPush: lnch.push_ms = dur;
      default: ;
    endcase
    r.armed          = lnch.armed;
    r.phase          = lnch.ph;
    r.flywheel_us    = lnch.fly_us;
    r.pusher_enabled = lnch.pusher_on;
    r.pusher_us      = lnch.pusher_on ? PushDriveUs : cfg_shadow.pusher_neutral_us;
    r.event_res      = ev;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_error(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      flag_error($sformatf("result %0d %s got %0d expected %0d",
                           results_seen, name, got, want));
  endtask

  // Result side is checked before the input side so a result never meets
  // an expectation queued at the same edge
  always @(posedge clk_i) begin : monitor_proc
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = awaited_results.pop_front();
          check_field("armed", armed_o, want.armed);
          check_field("phase", phase_o, want.phase);
          check_field("flywheel_us", flywheel_us_o, want.flywheel_us);
          check_field("pusher_enabled", pusher_enabled_o, want.pusher_enabled);
          check_field("pusher_us", pusher_us_o, want.pusher_us);
          check_field("event_res", event_res_o, want.event_res);
          case (want.event_res)
            EvComplete:   shots_done++;
            EvAutoDisarm: auto_disarms++;
            EvBusy:       busy_refusals++;
            default: ;
          endcase
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_o) begin
        awaited_results.push_back(step_launcher(mode_i, duration_ms_i));
        accept_count++;
      end
    end
  end

  // Watchdog: ends the run if nothing moves for too long
  always @(posedge clk_i) begin : watchdog_proc
    int unsigned quiet;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= StallLimit) begin
        $display("watchdog: no beat moved in %0d cycles", StallLimit);
        $display("launcher_fire_sequencer_test: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of beats with random gaps
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin : driver_proc
    beat_t       b;
    int unsigned burst_left;
    int unsigned gap_left;
    if (rst_ni && !(in_valid_i && accept_count != issue_count)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (send_q.size() != 0) begin
        b = send_q.pop_front();
        mode_i        <= b.mode;
        duration_ms_i <= b.dur;
        in_valid_i    <= 1'b1;
        issue_count++;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: 16-bit ready patterns plus requested long hold-offs
  always @(negedge clk_i) begin : receiver_proc
    logic [15:0] pat;
    logic [3:0]  pat_bit;
    int unsigned hold_left;
    int unsigned hold_served;
    logic        rdy;
    if (rst_ni) begin
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (pat_bit == 4'd0) begin
          case ($urandom_range(0, 3))
            0:       pat = '1;
            1:       pat = 16'($urandom());
            default: pat = 16'($urandom() | $urandom());
          endcase
        end
        rdy     = pat[pat_bit];
        pat_bit = pat_bit + 4'd1;
      end
      out_ready_i <= rdy;
    end else begin
      pat_bit = 4'd0;
    end
  end

  // ---------------------------------------------------------------------------
  // Register access and stimulus helpers
  // ---------------------------------------------------------------------------

  // Write one register, then read it back
  task automatic program_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegSpinup:  cfg_shadow.spin_delay_ms      = val[15:0];
      RegTimeout: cfg_shadow.idle_timeout_ms    = val[19:0];
      RegPower:   cfg_shadow.flywheel_power_pct = val[6:0];
      RegNeutral: cfg_shadow.pusher_neutral_us  = val[11:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegSpinup:  want = 32'(cfg_shadow.spin_delay_ms);
      RegTimeout: want = 32'(cfg_shadow.idle_timeout_ms);
      RegPower:   want = 32'(cfg_shadow.flywheel_power_pct);
      default:    want = 32'(cfg_shadow.pusher_neutral_us);
    endcase
    if (prdata != want)
      flag_error($sformatf("register %0d read %0d expected %0d", idx, prdata, want));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_config(input int unsigned spin, input int unsigned tmo,
                             input int unsigned pct, input int unsigned neutral);
    program_reg(RegSpinup, spin);
    program_reg(RegTimeout, tmo);
    program_reg(RegPower, pct);
    program_reg(RegNeutral, neutral);
  endtask

  // Spare modes are queued but not counted as commands
  task automatic add_beat(input logic [2:0] mode, input logic [15:0] dur);
    send_q.push_back('{mode: mode, dur: dur});
    if (mode <= ModeSetPush) queued_cmds++;
  endtask

  // Wait until every beat went in and every result came back
  task automatic wait_idle();
    do @(posedge clk_i);
    while (send_q.size() != 0 || accept_count != issue_count ||
           awaited_results.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  // Ticks with the odd interfering command thrown in
  task automatic add_ticks(input int unsigned n);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0, 1:    add_beat(ModeFire, 16'($urandom()));
        2:       add_beat(ModeSetPush, 16'($urandom_range(0, 5)));
        3:       add_beat(ModeArm, 16'($urandom()));
        default: add_beat(ModeTick, 16'($urandom()));
      endcase
    end
  endtask

  // Mostly complete arm/fire/tick sequences, the rest loose noise
  task automatic queue_shots(input int unsigned n);
    int unsigned target;
    target = queued_cmds + n;
    while (queued_cmds < target) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 3) == 0) add_beat(ModeDisarm, 16'($urandom()));
        add_beat(ModeArm, 16'($urandom()));
        if ($urandom_range(0, 4) == 0) add_beat(ModeSetPush, 16'($urandom_range(0, 4)));
        add_beat(ModeFire, ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 6)));
        add_ticks($urandom_range(2, 14));
        if ($urandom_range(0, 9) == 0) add_beat(ModeDisarm, 16'($urandom()));
        // long idle stretch to run into the auto disarm
        if ($urandom_range(0, 3) == 0) add_ticks($urandom_range(10, 45));
      end else begin
        add_beat(3'($urandom_range(0, ModeSpareHi)), 16'($urandom()));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_launcher();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: refused fire, spare modes, busy fire, disarm mid-shot
    add_beat(ModeTick, 16'hFFFF);
    add_beat(ModeFire, 16'd0);
    for (int m = ModeSpareLo; m <= ModeSpareHi; m++) add_beat(3'(m), 16'($urandom()));
    add_beat(ModeArm, 16'h0000);
    add_beat(ModeFire, 16'd3);
    add_beat(ModeFire, 16'd7);
    add_beat(ModeTick, 16'h5555);
    add_beat(ModeDisarm, 16'hAAAA);
    add_beat(ModeSetPush, 16'd0);
    wait_idle();

    // Zero spin-up and push time, zero timeout, power above the clamp
    load_config(0, 0, 127, 500);
    add_beat(ModeArm, 16'd0);
    add_beat(ModeFire, 16'd0);
    add_beat(ModeTick, 16'd0);
    add_beat(ModeTick, 16'd0);
    add_beat(ModeTick, 16'd0);
    add_beat(ModeSetPush, 16'hFFFF);
    add_beat(ModeArm, 16'd0);
    add_beat(ModeFire, 16'hFFFF);
    add_beat(ModeTick, 16'd0);
    add_beat(ModeTick, 16'd0);
    add_beat(ModeDisarm, 16'd0);
    wait_idle();

    // Random phases across several settings
    load_config(2, 12, 80, 2500);
    queue_shots(PhaseBeats);
    hold_requests++;
    wait_idle();

    load_config(0, 20'hFFFFF, 0, 1500);
    queue_shots(PhaseBeats);
    wait_idle();

    load_config(16'hFFFF, 1000000, 100, 500);
    queue_shots(PhaseBeats);
    wait_idle();

    load_config($urandom_range(0, 5), $urandom_range(0, 40),
                $urandom_range(0, 127), $urandom_range(500, 2500));
    queue_shots(PhaseBeats);
    wait_idle();

    load_config($urandom_range(0, 5), $urandom_range(0, 40),
                $urandom_range(0, 127), $urandom_range(500, 2500));
    queue_shots(PhaseBeats);
    hold_requests++;
    wait_idle();

    repeat (10) @(posedge clk_i);
    $display("covered %0d beats, %0d results checked, %0d register writes",
             accept_count, results_seen, reg_writes);
    $display("seen %0d completed shots, %0d auto disarms, %0d busy refusals, %0d mismatches",
             shots_done, auto_disarms, busy_refusals, mismatch_count);
    if (mismatch_count == 0) begin
      $display("launcher_fire_sequencer_test: done, clean");
    end else begin
      $display("launcher_fire_sequencer_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
